>>> rtl/cdt_pkg.sv
`default_nettype none

package cdt_pkg;

    // Longest word, in bytes, before a further word byte is refused
    localparam logic [12:0] MAX_TOKEN_LEN = 13'd4096;

    // Queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // Bytes with a meaning of their own
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        EV_WORD_BYTE,
        EV_WORD_END,
        EV_SEMI,
        EV_OPEN,
        EV_CLOSE,
        EV_DONE,
        EV_ERROR
    } t_event;

    typedef enum logic [2:0] {
        ERR_AFTER_QUOTE,
        ERR_STRAY_OPEN,
        ERR_STRAY_CLOSE,
        ERR_EARLY_END,
        ERR_TOO_LONG
    } t_err;

    // One output event
    typedef struct packed {
        t_event      kind;
        logic [7:0]  data;
        logic [2:0]  code;
    } t_res;

    // All events caused by one input byte (one or two)
    typedef struct packed {
        logic        two;
        t_res        res0;
        t_res        res1;
        logic [7:0]  wc;
        logic [15:0] line;
    } t_entry;

    // Tokenizer state
    typedef struct packed {
        logic        between_words;
        logic        need_separator;
        logic        in_comment;
        logic        escape_pending;
        logic        after_dollar;
        logic        in_double_quote;
        logic        in_single_quote;
        logic [12:0] word_length;
        logic [7:0]  word_count;
        logic [15:0] line_count;
        logic        error_hold;
    } t_tok_state;

    localparam t_tok_state TOK_RESET = '{
        between_words:   1'b1,
        need_separator:  1'b0,
        in_comment:      1'b0,
        escape_pending:  1'b0,
        after_dollar:    1'b0,
        in_double_quote: 1'b0,
        in_single_quote: 1'b0,
        word_length:     13'd0,
        word_count:      8'd0,
        line_count:      16'd1,
        error_hold:      1'b0
    };

    // Drop all word and statement state, keep line count and error hold
    function automatic t_tok_state clear_stmt(input t_tok_state s);
        t_tok_state r;
        r = TOK_RESET;
        r.line_count = s.line_count;
        r.error_hold = s.error_hold;
        return r;
    endfunction

    function automatic t_res mk_res(input t_event k, input logic [7:0] d,
                                    input logic [2:0] c);
        t_res r;
        r.kind = k;
        r.data = d;
        r.code = c;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cdt_front.sv
`default_nettype none

module cdt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_end,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output cdt_pkg::t_entry      o_entry
);
    import cdt_pkg::*;

    t_tok_state r_s, n_s;
    t_res       res [2];
    logic [1:0] cnt;
    logic [7:0] wc;
    logic [15:0] line16;
    logic       ws, go;
    logic       wb_a, wb_b;
    logic [7:0] va, vb;
    logic       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Classify the byte and work out next state and events
    always_comb begin
        n_s    = r_s;
        res[0] = mk_res(EV_WORD_BYTE, 8'd0, '0);
        res[1] = mk_res(EV_WORD_BYTE, 8'd0, '0);
        cnt    = 2'd0;
        wc     = r_s.word_count;
        line16 = r_s.line_count;
        ws     = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                 (i_byte == CH_CR) || (i_byte == CH_LF);
        go     = 1'b1;
        wb_a   = 1'b0;
        wb_b   = 1'b0;
        va     = i_byte;
        vb     = i_byte;

        if (i_end) begin
            if (!r_s.error_hold && (r_s.word_count != 8'd0 || !r_s.between_words)) begin
                res[cnt[0]] = mk_res(EV_ERROR, 8'd0, 3'(ERR_EARLY_END));
                cnt = cnt + 2'd1;
            end
            res[cnt[0]] = mk_res(EV_DONE, 8'd0, '0);
            cnt = cnt + 2'd1;
            n_s = TOK_RESET;
        end else if (!r_s.error_hold) begin
            if (i_byte == CH_LF) begin
                if (n_s.line_count != 16'hFFFF) begin
                    n_s.line_count = n_s.line_count + 16'd1;
                end
                n_s.in_comment = 1'b0;
            end
            line16 = n_s.line_count;
            if (!n_s.in_comment) begin
                if (n_s.escape_pending) begin
                    // Resolve the escaped byte
                    n_s.escape_pending = 1'b0;
                    wb_a = 1'b1;
                    case (i_byte)
                        CH_DQUOTE, CH_SQUOTE, CH_BSLASH: va = i_byte;
                        CH_LOW_T: va = CH_TAB;
                        CH_LOW_R: va = CH_CR;
                        CH_LOW_N: va = CH_LF;
                        default: begin
                            va   = CH_BSLASH;
                            wb_b = 1'b1;
                        end
                    endcase
                end else begin
                    // Byte right after a closing quote
                    if (n_s.need_separator) begin
                        go = 1'b0;
                        if (ws) begin
                            n_s.between_words  = 1'b1;
                            n_s.need_separator = 1'b0;
                        end else if (i_byte == CH_SEMI) begin
                            res[cnt[0]] = mk_res(EV_SEMI, 8'd0, '0);
                            cnt = cnt + 2'd1;
                            n_s = clear_stmt(n_s);
                        end else if (i_byte == CH_LBRACE) begin
                            res[cnt[0]] = mk_res(EV_OPEN, 8'd0, '0);
                            cnt = cnt + 2'd1;
                            n_s = clear_stmt(n_s);
                        end else if (i_byte == CH_RPAREN) begin
                            n_s.between_words  = 1'b1;
                            n_s.need_separator = 1'b0;
                            go = 1'b1;
                        end else begin
                            res[cnt[0]] = mk_res(EV_ERROR, 8'd0, 3'(ERR_AFTER_QUOTE));
                            cnt = cnt + 2'd1;
                            n_s.error_hold = 1'b1;
                        end
                    end
                    if (go) begin
                        if (n_s.between_words) begin
                            // Start of a word or a statement mark
                            if (!ws) begin
                                case (i_byte)
                                    CH_SEMI, CH_LBRACE: begin
                                        if (n_s.word_count == 8'd0) begin
                                            res[cnt[0]] = mk_res(EV_ERROR, 8'd0,
                                                                 3'(ERR_STRAY_OPEN));
                                            cnt = cnt + 2'd1;
                                            n_s.error_hold = 1'b1;
                                        end else begin
                                            res[cnt[0]] = mk_res(
                                                (i_byte == CH_SEMI) ? EV_SEMI : EV_OPEN,
                                                8'd0, '0);
                                            cnt = cnt + 2'd1;
                                            n_s = clear_stmt(n_s);
                                        end
                                    end
                                    CH_RBRACE: begin
                                        if (n_s.word_count != 8'd0) begin
                                            res[cnt[0]] = mk_res(EV_ERROR, 8'd0,
                                                                 3'(ERR_STRAY_CLOSE));
                                            cnt = cnt + 2'd1;
                                            n_s.error_hold = 1'b1;
                                        end else begin
                                            res[cnt[0]] = mk_res(EV_CLOSE, 8'd0, '0);
                                            cnt = cnt + 2'd1;
                                            n_s = clear_stmt(n_s);
                                        end
                                    end
                                    CH_HASH: n_s.in_comment = 1'b1;
                                    CH_BSLASH: begin
                                        n_s.escape_pending = 1'b1;
                                        n_s.between_words  = 1'b0;
                                    end
                                    CH_DQUOTE: begin
                                        n_s.in_double_quote = 1'b1;
                                        n_s.between_words   = 1'b0;
                                    end
                                    CH_SQUOTE: begin
                                        n_s.in_single_quote = 1'b1;
                                        n_s.between_words   = 1'b0;
                                    end
                                    default: begin
                                        n_s.between_words = 1'b0;
                                        wb_a = 1'b1;
                                    end
                                endcase
                            end
                        end else if (i_byte == CH_LBRACE && n_s.after_dollar) begin
                            wb_a = 1'b1;
                        end else begin
                            // Inside a word
                            n_s.after_dollar = 1'b0;
                            if (i_byte == CH_BSLASH) begin
                                n_s.escape_pending = 1'b1;
                            end else if (i_byte == CH_DOLLAR) begin
                                n_s.after_dollar = 1'b1;
                                wb_a = 1'b1;
                            end else if (n_s.in_double_quote || n_s.in_single_quote) begin
                                if ((n_s.in_double_quote && i_byte == CH_DQUOTE) ||
                                    (!n_s.in_double_quote && i_byte == CH_SQUOTE)) begin
                                    n_s.in_double_quote = 1'b0;
                                    n_s.in_single_quote = 1'b0;
                                    n_s.need_separator  = 1'b1;
                                    if (n_s.word_count != 8'hFF) begin
                                        n_s.word_count = n_s.word_count + 8'd1;
                                    end
                                    n_s.word_length = '0;
                                    wc = n_s.word_count;
                                    res[cnt[0]] = mk_res(EV_WORD_END, 8'd0, '0);
                                    cnt = cnt + 2'd1;
                                end else begin
                                    wb_a = 1'b1;
                                end
                            end else if (ws || i_byte == CH_SEMI || i_byte == CH_LBRACE) begin
                                n_s.between_words = 1'b1;
                                if (n_s.word_count != 8'hFF) begin
                                    n_s.word_count = n_s.word_count + 8'd1;
                                end
                                n_s.word_length = '0;
                                res[cnt[0]] = mk_res(EV_WORD_END, 8'd0, '0);
                                cnt = cnt + 2'd1;
                                wc = n_s.word_count;
                                if (i_byte == CH_SEMI) begin
                                    res[cnt[0]] = mk_res(EV_SEMI, 8'd0, '0);
                                    cnt = cnt + 2'd1;
                                    n_s = clear_stmt(n_s);
                                end else if (i_byte == CH_LBRACE) begin
                                    res[cnt[0]] = mk_res(EV_OPEN, 8'd0, '0);
                                    cnt = cnt + 2'd1;
                                    n_s = clear_stmt(n_s);
                                end
                            end else begin
                                wb_a = 1'b1;
                            end
                        end
                    end
                end
            end

            // Emit word bytes, refusing those past the length limit
            if (wb_a && !n_s.error_hold) begin
                if (n_s.word_length >= MAX_TOKEN_LEN) begin
                    res[cnt[0]] = mk_res(EV_ERROR, 8'd0, 3'(ERR_TOO_LONG));
                    cnt = cnt + 2'd1;
                    n_s.error_hold = 1'b1;
                end else begin
                    n_s.word_length = n_s.word_length + 13'd1;
                    res[cnt[0]] = mk_res(EV_WORD_BYTE, va, '0);
                    cnt = cnt + 2'd1;
                end
            end
            if (wb_b && !n_s.error_hold) begin
                if (n_s.word_length >= MAX_TOKEN_LEN) begin
                    res[cnt[0]] = mk_res(EV_ERROR, 8'd0, 3'(ERR_TOO_LONG));
                    cnt = cnt + 2'd1;
                    n_s.error_hold = 1'b1;
                end else begin
                    n_s.word_length = n_s.word_length + 13'd1;
                    res[cnt[0]] = mk_res(EV_WORD_BYTE, vb, '0);
                    cnt = cnt + 2'd1;
                end
            end
        end
    end

    // Pack the events of this byte for the queue
    always_comb begin
        o_entry.two  = cnt[1];
        o_entry.res0 = res[0];
        o_entry.res1 = res[1];
        o_entry.wc   = wc;
        o_entry.line = line16;
        o_push       = accept && (cnt != 2'd0);
    end

    // Advance the tokenizer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= TOK_RESET;
        end else if (accept) begin
            r_s <= n_s;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cdt_fifo.sv
`default_nettype none

module cdt_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cdt_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output cdt_pkg::t_entry      o_entry
);
    import cdt_pkg::*;

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/cdt_back.sv
`default_nettype none

module cdt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire cdt_pkg::t_entry i_q_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_byte,
    output logic [7:0]           o_wc,
    output logic [2:0]           o_code,
    output logic [15:0]          o_line,
    output logic                 o_last
);
    import cdt_pkg::*;

    t_entry r_ent;
    logic   r_valid, r_idx;
    t_res   cur;
    logic   last, take;

    assign cur     = r_idx ? r_ent.res1 : r_ent.res0;
    assign last    = !r_ent.two || r_idx;
    assign take    = r_valid && i_ready;
    assign o_pop   = i_q_valid && (!r_valid || (take && last));
    assign o_valid = r_valid;
    assign o_kind  = cur.kind;
    assign o_byte  = cur.data;
    assign o_code  = cur.code;
    assign o_wc    = r_ent.wc;
    assign o_line  = r_ent.line;
    assign o_last  = last;

    // Load the next entry or step to its second event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 1'b0;
        end else if (take) begin
            r_valid <= !last;
            r_idx   <= !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/config_directive_tokenizer.sv
`default_nettype none

// Configuration text tokenizer.
// Slave channel: one text byte per item in s_tdata; s_tlast marks the end of
// the text (the byte is then ignored). Master channel: one event per item,
// kind in m_tuser; m_tlast flags the last event caused by an input item.
// A byte may produce no event (whitespace, comments, bytes after an error),
// one event, or two (word end followed by ';' or '{', an escape that yields
// two bytes, a byte followed by a length error, early end plus done).
// The front tokenizer takes one byte per cycle whenever its four-entry queue
// has room; the back stage sends one event per cycle while m_tready is high,
// so a byte giving two events holds it for both. Events of an accepted byte
// are written into the queue, then into the output stage, and only then valid.
// Reset returns the tokenizer to the start of text, line count 1, and
// empties the queue. When the receiver stalls, the output holds and the queue
// fills; once it is full s_tready drops until the back stage drains an entry.
// The end marker also returns the tokenizer to its start state.
module config_directive_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  wire logic        i_s_tlast,   // end_of_input
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [7:0] word_byte, [15:8] words_in_statement,
                                          // [18:16] error_code, [34:19] line_number, zeros
    output logic [2:0]       o_m_tuser,   // [2:0] event_kind
    output logic             o_m_tlast    // last_of_run
);
    import cdt_pkg::*;

    logic        q_full, q_push, q_pop, q_valid;
    t_entry      f_entry, q_entry;
    logic [7:0]  b_byte, b_wc;
    logic [2:0]  b_code;
    logic [15:0] b_line;

    cdt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_end    (i_s_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (f_entry)
    );

    cdt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    cdt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (o_m_tuser),
        .o_byte    (b_byte),
        .o_wc      (b_wc),
        .o_code    (b_code),
        .o_line    (b_line),
        .o_last    (o_m_tlast)
    );

    // Pack the event fields
    assign o_m_tdata = {5'd0, b_line, b_code, b_wc, b_byte};

endmodule

`default_nettype wire
